// ===== rtl/lpi_pkg.sv =====
package lpi_pkg;

	localparam int MAX_POINTS = 64;
	localparam int MAX_DEGREE = 15;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int MAG_W      = 47;
	localparam int PROD_W     = 56;
	localparam int DIGIT_W    = 8;
	localparam int DIV_STEPS  = PROD_W / DIGIT_W;
	localparam int DCNT_W     = $clog2(DIV_STEPS);
	localparam int MUL_W      = 58;
	localparam int ACC_W      = 64;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

	localparam logic CFG_POINT_COUNT = 1'b0;
	localparam logic CFG_DEGREE      = 1'b1;

	typedef struct packed {
		logic               req_type;
		logic [5:0]         point_index;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [23:0] argument;
	} lpi_in_t;

	typedef struct packed {
		logic signed [15:0] result_x;
		logic signed [15:0] result_y;
	} lpi_out_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SETUP,
		ST_PICK,
		ST_D0_RD,
		ST_D0_CAP,
		ST_W_INIT,
		ST_F_CHECK,
		ST_F_MH,
		ST_F_ML,
		ST_F_DLOAD,
		ST_F_DIV,
		ST_F_SAT,
		ST_P_RD,
		ST_P_CAP,
		ST_P_XH,
		ST_P_XL,
		ST_P_YH,
		ST_P_YL,
		ST_P_YACC,
		ST_FIN,
		ST_DONE
	} lpi_state_t;

	typedef enum logic [1:0] {
		MB_MT,
		MB_X,
		MB_Y
	} lpi_mul_b_t;

	typedef struct packed {
		logic       ram_we;
		logic       load_arg;
		logic       setup;
		logic       init_j;
		logic       init_w;
		logic       calc_factor;
		logic       inc_k;
		logic       mul_hi;
		lpi_mul_b_t mul_b;
		logic       hold_ld;
		logic       div_ld;
		logic       div_step;
		logic       mag_sat;
		logic       rd_base;
		logic       pt_cap;
		logic       acc_clr;
		logic       acc_x;
		logic       acc_y;
		logic       inc_j;
		logic       res_d0;
		logic       res_fin;
	} lpi_cmd_t;

	typedef struct packed {
		logic degz;
		logic k_past;
		logic k_eq_j;
		logic j_last;
	} lpi_status_t;

endpackage

// ===== rtl/lpi_ram.sv =====
module lpi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/lpi_ctrl.sv =====
module lpi_ctrl import lpi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        req_type,
	input  lpi_status_t status,
	output lpi_cmd_t    cmd,
	output logic        busy,
	output logic        done
);

	lpi_state_t         state_q, state_d;
	logic [DCNT_W-1:0]  cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		cmd       = '0;
		cmd.mul_b = MB_MT;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == REQ_EVAL) begin
						cmd.load_arg = 1'b1;
						state_d      = ST_SETUP;
					end else begin
						cmd.ram_we = 1'b1;
					end
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_PICK;
			end
			ST_PICK: begin
				cmd.init_j  = 1'b1;
				cmd.acc_clr = 1'b1;
				state_d     = status.degz ? ST_D0_RD : ST_W_INIT;
			end
			ST_D0_RD: begin
				cmd.rd_base = 1'b1;
				state_d     = ST_D0_CAP;
			end
			ST_D0_CAP: begin
				cmd.rd_base = 1'b1;
				cmd.res_d0  = 1'b1;
				state_d     = ST_DONE;
			end
			ST_W_INIT: begin
				cmd.init_w = 1'b1;
				state_d    = ST_F_CHECK;
			end
			ST_F_CHECK: begin
				if (status.k_past) begin
					state_d = ST_P_RD;
				end else if (status.k_eq_j) begin
					cmd.inc_k = 1'b1;
				end else begin
					cmd.calc_factor = 1'b1;
					state_d         = ST_F_MH;
				end
			end
			ST_F_MH: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_F_ML;
			end
			ST_F_ML: begin
				cmd.hold_ld = 1'b1;
				state_d     = ST_F_DLOAD;
			end
			ST_F_DLOAD: begin
				cmd.div_ld = 1'b1;
				cnt_d      = '0;
				state_d    = ST_F_DIV;
			end
			ST_F_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DCNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_F_SAT;
				end
			end
			ST_F_SAT: begin
				cmd.mag_sat = 1'b1;
				cmd.inc_k   = 1'b1;
				state_d     = ST_F_CHECK;
			end
			ST_P_RD: begin
				state_d = ST_P_CAP;
			end
			ST_P_CAP: begin
				cmd.pt_cap = 1'b1;
				state_d    = ST_P_XH;
			end
			ST_P_XH: begin
				cmd.mul_hi = 1'b1;
				cmd.mul_b  = MB_X;
				state_d    = ST_P_XL;
			end
			ST_P_XL: begin
				cmd.mul_b   = MB_X;
				cmd.hold_ld = 1'b1;
				state_d     = ST_P_YH;
			end
			ST_P_YH: begin
				cmd.acc_x  = 1'b1;
				cmd.mul_hi = 1'b1;
				cmd.mul_b  = MB_Y;
				state_d    = ST_P_YL;
			end
			ST_P_YL: begin
				cmd.mul_b   = MB_Y;
				cmd.hold_ld = 1'b1;
				state_d     = ST_P_YACC;
			end
			ST_P_YACC: begin
				cmd.acc_y = 1'b1;
				cmd.inc_j = 1'b1;
				state_d   = status.j_last ? ST_FIN : ST_W_INIT;
			end
			ST_FIN: begin
				cmd.res_fin = 1'b1;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// ===== rtl/lpi_datapath.sv =====
module lpi_datapath import lpi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  lpi_in_t     item,
	input  lpi_cmd_t    cmd,
	output lpi_status_t status,
	output lpi_out_t    result
);

	localparam logic [MAG_W-1:0] WEIGHT_CAP = MAG_W'(1) << 46;
	localparam logic [MAG_W-1:0] ONE_Q32    = MAG_W'(1) << 32;
	localparam logic signed [ACC_W+1:0] ACC_CAP = (ACC_W+2)'(1) <<< 62;

	// Configuration registers.
	logic [6:0] pc_q;
	logic [3:0] deg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= 7'd1;
			deg_q <= 4'd0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_POINT_COUNT) begin
				pc_q <= cfg_data;
			end else begin
				deg_q <= cfg_data[3:0];
			end
		end
	end

	logic signed [23:0] arg_q;
	logic [IDX_W-1:0]   base_q, nb_q, nf_q;
	logic               degz_q;
	logic [CNT_W-1:0]   j_q, k_q;
	logic [23:0]        mt_q;
	logic [3:0]         md_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic signed [MUL_W-1:0] mul_q, hold_q;
	logic [PROD_W-1:0]  div_q;
	logic [3:0]         rem_q;
	logic [31:0]        pt_q;
	logic signed [ACC_W-1:0] accx_q, accy_q;
	lpi_out_t           res_q;

	// Window setup.
	logic [6:0]        n_c;
	logic [IDX_W-1:0]  last_c;
	logic signed [8:0] base_s;
	logic [IDX_W-1:0]  base_c;
	logic [3:0]        pwc_c;
	logic [6:0]        nf_s;
	logic signed [7:0] nb_s;
	logic [IDX_W-1:0]  nb_c, nf_c;

	always_comb begin
		if (pc_q == 7'd0) begin
			n_c = 7'd1;
		end else if (pc_q > 7'(MAX_POINTS)) begin
			n_c = 7'(MAX_POINTS);
		end else begin
			n_c = pc_q;
		end
		last_c = IDX_W'(n_c - 7'd1);
		base_s = 9'($signed(arg_q[23:16]));
		if (arg_q[23] && (arg_q[15:0] != 16'd0)) begin
			base_s = base_s + 9'sd1;
		end
		if (base_s < 0) begin
			base_c = '0;
		end else if (base_s > $signed({3'b000, last_c})) begin
			base_c = last_c;
		end else begin
			base_c = base_s[IDX_W-1:0];
		end
		if ({2'b00, deg_q} > last_c) begin
			pwc_c = last_c[3:0];
		end else begin
			pwc_c = deg_q;
		end
		nf_s = {1'b0, base_c} + 7'd1 + {4'd0, pwc_c[3:1]};
		nb_s = '0;
		if (nf_s > {1'b0, last_c}) begin
			nf_c = last_c;
			nb_c = last_c - {2'b00, pwc_c};
		end else begin
			nb_s = $signed({1'b0, nf_s}) - $signed({4'd0, pwc_c});
			if (nb_s < 0) begin
				nb_c = '0;
				nf_c = {2'b00, pwc_c};
			end else begin
				nb_c = nb_s[IDX_W-1:0];
				nf_c = nf_s[IDX_W-1:0];
			end
		end
	end

	assign status.degz   = degz_q;
	assign status.k_past = (k_q > {1'b0, nf_q});
	assign status.k_eq_j = (k_q == j_q);
	assign status.j_last = (j_q[IDX_W-1:0] == nf_q);

	// Factor terms: |argument - k| and |j - k|.
	logic signed [24:0] t_c;
	logic signed [7:0]  d_c;

	assign t_c = 25'(arg_q) - $signed({3'b000, k_q[IDX_W-1:0], 16'h0000});
	assign d_c = $signed({1'b0, j_q}) - $signed({1'b0, k_q});

	// Shared multiplier.
	logic signed [32:0]      mul_a;
	logic signed [24:0]      mul_b;
	logic signed [MUL_W-1:0] mul_p;

	always_comb begin
		mul_a = cmd.mul_hi ? $signed({18'd0, mag_q[MAG_W-1:32]}) : $signed({1'b0, mag_q[31:0]});
		case (cmd.mul_b)
			MB_MT:   mul_b = $signed({1'b0, mt_q});
			MB_X:    mul_b = 25'($signed(pt_q[15:0]));
			MB_Y:    mul_b = 25'($signed(pt_q[31:16]));
			default: mul_b = '0;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Eight quotient bits per cycle; the remainder stays below the divisor.
	logic [4:0]         r_c;
	logic [DIGIT_W-1:0] qd_c;

	always_comb begin
		r_c  = {1'b0, rem_q};
		qd_c = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			r_c = {r_c[3:0], div_q[PROD_W-1-i]};
			if (r_c >= {1'b0, md_q}) begin
				r_c            = r_c - {1'b0, md_q};
				qd_c[DIGIT_W-1-i] = 1'b1;
			end
		end
	end

	// Weighted point accumulation with saturation.
	logic signed [ACC_W+1:0] term_c, sum_c, tn_c, acc_in_c, acc_new_c;

	always_comb begin
		term_c   = ((ACC_W+2)'(hold_q) <<< 32) + (ACC_W+2)'(mul_q);
		tn_c     = neg_q ? -term_c : term_c;
		acc_in_c = cmd.acc_y ? (ACC_W+2)'(accy_q) : (ACC_W+2)'(accx_q);
		sum_c    = acc_in_c + tn_c;
		if (sum_c > ACC_CAP) begin
			acc_new_c = ACC_CAP;
		end else if (sum_c < -ACC_CAP) begin
			acc_new_c = -ACC_CAP;
		end else begin
			acc_new_c = sum_c;
		end
	end

	function automatic logic signed [15:0] round_out(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W+1:0] v;
		logic signed [ACC_W+1:0] r;
		v = (ACC_W+2)'(acc) + ((ACC_W+2)'(1) <<< 31);
		if (v >= 0) begin
			r = v >>> 32;
		end else begin
			r = -((-v) >>> 32);
		end
		if (r > 32767) begin
			return 16'sh7fff;
		end else if (r < -32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	// Point store.
	logic [31:0]      ram_rdata;
	logic [IDX_W-1:0] ram_raddr;

	assign ram_raddr = cmd.rd_base ? base_q : j_q[IDX_W-1:0];

	lpi_ram #(
		.WIDTH(32),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.ram_we),
		.waddr(item.point_index),
		.wdata({item.point_y, item.point_x}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (cmd.load_arg) begin
			arg_q <= item.argument;
		end
		if (cmd.setup) begin
			base_q <= base_c;
			nb_q   <= nb_c;
			nf_q   <= nf_c;
			degz_q <= (pwc_c == 4'd0);
		end
		if (cmd.init_j) begin
			j_q <= {1'b0, nb_q};
		end else if (cmd.inc_j) begin
			j_q <= j_q + 1'b1;
		end
		if (cmd.init_w) begin
			k_q   <= {1'b0, nb_q};
			mag_q <= ONE_Q32;
			neg_q <= 1'b0;
		end else begin
			if (cmd.inc_k) begin
				k_q <= k_q + 1'b1;
			end
			if (cmd.calc_factor) begin
				mt_q  <= t_c[24] ? 24'(-t_c) : t_c[23:0];
				md_q  <= d_c[7] ? 4'(-d_c) : d_c[3:0];
				neg_q <= neg_q ^ t_c[24] ^ d_c[7];
			end
			if (cmd.mag_sat) begin
				mag_q <= (div_q > PROD_W'(WEIGHT_CAP)) ? WEIGHT_CAP : div_q[MAG_W-1:0];
			end
		end
		if (cmd.hold_ld) begin
			hold_q <= mul_q;
		end
		if (cmd.div_ld) begin
			div_q <= {hold_q[39:0], 16'h0000} + {14'd0, mul_q[MUL_W-1:16]};
			rem_q <= '0;
		end else if (cmd.div_step) begin
			div_q <= {div_q[PROD_W-DIGIT_W-1:0], qd_c};
			rem_q <= r_c[3:0];
		end
		if (cmd.pt_cap) begin
			pt_q <= ram_rdata;
		end
		if (cmd.acc_clr) begin
			accx_q <= '0;
			accy_q <= '0;
		end else if (cmd.acc_x) begin
			accx_q <= acc_new_c[ACC_W-1:0];
		end else if (cmd.acc_y) begin
			accy_q <= acc_new_c[ACC_W-1:0];
		end
		if (cmd.res_d0) begin
			res_q.result_x <= ram_rdata[15:0];
			res_q.result_y <= ram_rdata[31:16];
		end else if (cmd.res_fin) begin
			res_q.result_x <= round_out(accx_q);
			res_q.result_y <= round_out(accy_q);
		end
	end

	assign result = res_q;

endmodule

// ===== rtl/lagrange_point_interpolator_core.sv =====
// Lagrange interpolator over a store of up to 64 control points on a uniform
// grid. A transfer is accepted at a rising edge where start is high and busy
// is low. A write item stores one point at the accepting edge and leaves busy
// low, so writes can follow back to back. An evaluate item raises busy and
// uses the degree clamped to point_count minus one; busy falls at the edge
// that takes the result, after which the next transfer can be accepted. The
// evaluation time is set by the single shared multiplier, used for the high
// and low half of every factor of every weight and for each weighted point,
// and by the weight divider, which retires eight quotient bits per cycle and
// is visited once for every factor of every weight. The result is on result
// when done is high for a single cycle; the receiver cannot stall it, so it
// must take the transfer in that cycle. Configuration is to be written on
// cfg_we only while the block is idle, which the block itself does not
// enforce; index 0 for point_count and index 1 for degree.
// Evaluating over a slot that was never written gives an undefined result.
module lagrange_point_interpolator_core import lpi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  lpi_in_t    item,
	output logic       done,
	output lpi_out_t   result,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [6:0] cfg_data
);

	// Command and status between the sequencer and the arithmetic.
	lpi_cmd_t    cmd;
	lpi_status_t status;

	// The sequencer walks the window points and, for each, every factor of
	// its weight, then accumulates the weighted x and y.
	lpi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.req_type(item.req_type),
		.status  (status),
		.cmd     (cmd),
		.busy    (busy),
		.done    (done)
	);

	// The datapath holds the configuration, the point store, the shared
	// multiplier, the divider and the two accumulators.
	lpi_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd),
		.status   (status),
		.result   (result)
	);

endmodule
